// ===== rtl/core/parst_pkg.sv =====
// Shared constants and controller/datapath interface types for the range-sum tree.
package parst_pkg;

   localparam int MAX_LEN     = 1024;
   localparam int LEN_W       = 11;
   localparam int VALUE_W     = 32;
   localparam int NODE_COUNT  = 4 * MAX_LEN;
   localparam int NODE_AW     = $clog2(NODE_COUNT);
   localparam int STACK_DEPTH = 16;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_IGNORED = 1'b1;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic mem_read;
      logic add_write;
      logic descend;
      logic push_go_left;
      logic pop;
      logic accumulate;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic req_is_add;
      logic add_ok;
      logic is_leaf;
      logic disjoint;
      logic covered;
      logic stack_empty;
   } sts_type;

endpackage

// ===== rtl/core/parst_datapath.sv =====
// Node memory, node cursor, query stack, accumulator and length register.
module parst_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [parst_pkg::LEN_W-1:0]          csr_wr_data,
   input  logic                                 req_func,
   input  logic [parst_pkg::LEN_W-1:0]          req_position,
   input  logic [parst_pkg::LEN_W-1:0]          req_right_end,
   input  logic signed [parst_pkg::VALUE_W-1:0] req_delta,
   input  parst_pkg::cmd_type                   cmd,
   output parst_pkg::sts_type                   sts,
   output logic signed [parst_pkg::VALUE_W-1:0] rsp_range_total,
   output logic                                 rsp_status
);
   import parst_pkg::*;

   typedef struct packed {
      logic [NODE_AW-1:0] v;
      logic [LEN_W-1:0]   l;
      logic [LEN_W-1:0]   r;
   } node_type;

   logic [LEN_W-1:0]   len_ff;
   logic [LEN_W-1:0]   n_act;
   logic [LEN_W-1:0]   pos_ff, right_ff;
   logic [VALUE_W-1:0] delta_ff;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               status_ff;
   logic [NODE_AW-1:0] v_ff, v_in;
   logic [LEN_W-1:0]   l_ff, l_in, r_ff, r_in;
   logic [STACK_AW:0]  sp_ff, sp_in, sp_m1;
   logic [NODE_AW-1:0] clr_cnt_ff;
   logic [VALUE_W-1:0] rdata_ff;
   node_type           stack_ff [STACK_DEPTH];
   node_type           stack_top;
   logic [VALUE_W-1:0] mem [NODE_COUNT];

   logic [LEN_W:0]     mid_sum;
   logic [LEN_W-1:0]   mid, mid_plus;
   logic [NODE_AW-1:0] v_left, v_right;
   logic               mem_we;
   logic [NODE_AW-1:0] waddr;
   logic [VALUE_W-1:0] wdata;

   // clamp the configured length into 1..MAX_LEN
   always_comb begin
      if (len_ff == '0) begin
         n_act = LEN_W'(1);
      end else if (len_ff > LEN_W'(MAX_LEN)) begin
         n_act = LEN_W'(MAX_LEN);
      end else begin
         n_act = len_ff;
      end
   end

   assign mid_sum  = {1'b0, l_ff} + {1'b0, r_ff};
   assign mid      = mid_sum[LEN_W:1];
   assign mid_plus = mid + LEN_W'(1);
   assign v_left   = {v_ff[NODE_AW-2:0], 1'b0};
   assign v_right  = {v_ff[NODE_AW-2:0], 1'b1};
   assign sp_m1    = sp_ff - (STACK_AW+1)'(1);
   assign stack_top = stack_ff[sp_m1[STACK_AW-1:0]];

   assign sts.clear_last  = &clr_cnt_ff;
   assign sts.req_is_add  = (req_func == FUNC_ADD);
   assign sts.add_ok      = (req_position != '0) && (req_position <= n_act);
   assign sts.is_leaf     = (l_ff == r_ff);
   assign sts.disjoint    = (pos_ff > right_ff) || (pos_ff > r_ff) || (right_ff < l_ff);
   assign sts.covered     = (pos_ff <= l_ff) && (r_ff <= right_ff);
   assign sts.stack_empty = (sp_ff == '0);

   always_comb begin
      v_in   = v_ff;
      l_in   = l_ff;
      r_in   = r_ff;
      sp_in  = sp_ff;
      acc_in = acc_ff;
      if (cmd.load) begin
         v_in   = NODE_AW'(1);
         l_in   = LEN_W'(1);
         r_in   = n_act;
         sp_in  = '0;
         acc_in = '0;
      end else if (cmd.descend) begin
         if (pos_ff <= mid) begin
            v_in = v_left;
            r_in = mid;
         end else begin
            v_in = v_right;
            l_in = mid_plus;
         end
      end else if (cmd.push_go_left) begin
         v_in  = v_left;
         r_in  = mid;
         sp_in = sp_ff + (STACK_AW+1)'(1);
      end else if (cmd.pop) begin
         v_in  = stack_top.v;
         l_in  = stack_top.l;
         r_in  = stack_top.r;
         sp_in = sp_m1;
      end
      if (cmd.accumulate) begin
         acc_in = acc_ff + rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= LEN_W'(MAX_LEN);
         sp_ff      <= '0;
         clr_cnt_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            len_ff     <= csr_wr_data;
            clr_cnt_ff <= '0;
         end else if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + NODE_AW'(1);
         end
         sp_ff <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      l_ff   <= l_in;
      r_ff   <= r_in;
      acc_ff <= acc_in;
      if (cmd.load) begin
         pos_ff    <= req_position;
         right_ff  <= req_right_end;
         delta_ff  <= req_delta;
         status_ff <= (sts.req_is_add && !sts.add_ok) ? STATUS_IGNORED : STATUS_DONE;
      end
      if (cmd.push_go_left) begin
         stack_ff[sp_ff[STACK_AW-1:0]] <= '{v: v_right, l: mid_plus, r: r_ff};
      end
   end

   // one write port shared by the clearing sweep and the add path
   assign mem_we = cmd.clear_step | cmd.add_write;
   assign waddr  = cmd.clear_step ? clr_cnt_ff : v_ff;
   assign wdata  = cmd.clear_step ? '0 : (rdata_ff + delta_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.mem_read) begin
         rdata_ff <= mem[v_ff];
      end
   end

   assign rsp_range_total = acc_ff;
   assign rsp_status      = status_ff;

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push_go_left |-> sp_ff < (STACK_AW+1)'(STACK_DEPTH))
      else $error("query stack overflow");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> sp_ff != '0)
      else $error("pop from empty query stack");

   a_load_root: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (v_ff == NODE_AW'(1)) && (acc_ff == '0) && (sp_ff == '0))
      else $error("cursor not at root after load");

endmodule

// ===== rtl/core/parst_ctrl.sv =====
// Sequencer for clearing sweep, add path walk and query traversal.
module parst_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               csr_wr_en,
   input  parst_pkg::sts_type sts,
   output parst_pkg::cmd_type cmd,
   output logic               busy,
   output logic               rsp_valid
);
   import parst_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR   = 7'b0000001,
      ST_IDLE    = 7'b0000010,
      ST_A_READ  = 7'b0000100,
      ST_A_WRITE = 7'b0001000,
      ST_Q_VISIT = 7'b0010000,
      ST_Q_ACC   = 7'b0100000,
      ST_DONE    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (!sts.req_is_add) begin
                  state_in = ST_Q_VISIT;
               end else if (sts.add_ok) begin
                  state_in = ST_A_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_A_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_A_WRITE;
         end
         ST_A_WRITE: begin
            // every node on the path gains the same delta
            cmd.add_write = 1'b1;
            if (sts.is_leaf) begin
               state_in = ST_DONE;
            end else begin
               cmd.descend = 1'b1;
               state_in    = ST_A_READ;
            end
         end
         ST_Q_VISIT: begin
            if (sts.disjoint) begin
               if (sts.stack_empty) state_in = ST_DONE;
               else cmd.pop = 1'b1;
            end else if (sts.covered) begin
               cmd.mem_read = 1'b1;
               state_in     = ST_Q_ACC;
            end else begin
               // hold the right half for later, walk into the left half
               cmd.push_go_left = 1'b1;
            end
         end
         ST_Q_ACC: begin
            cmd.accumulate = 1'b1;
            if (sts.stack_empty) begin
               state_in = ST_DONE;
            end else begin
               cmd.pop  = 1'b1;
               state_in = ST_Q_VISIT;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      // a length write restarts the clearing sweep
      if (csr_wr_en) state_in = ST_CLEAR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   a_done_one_beat: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> state_ff != ST_DONE)
      else $error("result beat held longer than one cycle");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !csr_wr_en) |=> busy)
      else $error("accepted beat did not make the block busy");

   a_csr_starts_clear: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> state_ff == ST_CLEAR)
      else $error("length write did not start the clearing sweep");

endmodule

// ===== rtl/core/point_add_range_sum_tree_top.sv =====
// Top level of the point-add / range-sum segment tree.
//
//  channel   ports                                         handshake
//  --------  --------------------------------------------  ---------------------------
//  request   req_func req_position req_right_end req_delta  start & !busy
//  result    rsp_range_total rsp_status                    rsp_valid, one cycle
//  config    csr_wr_data                                   csr_wr_en
//
// An add reads and then writes each node on the path from the root down to the leaf;
// a query visits nodes from the root, reads and sums each covered node and keeps
// the right half of each split node on a stack. Both walk the node memory.
// After reset, and after each csr write, a clearing sweep of all 4096 node memory
// entries runs with busy high. The result beat cannot be stalled; busy stays high
// through the cycle that shows it.
module point_add_range_sum_tree_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_func,
   input  logic [parst_pkg::LEN_W-1:0]          req_position,
   input  logic [parst_pkg::LEN_W-1:0]          req_right_end,
   input  logic signed [parst_pkg::VALUE_W-1:0] req_delta,
   output logic                                 rsp_valid,
   output logic signed [parst_pkg::VALUE_W-1:0] rsp_range_total,
   output logic                                 rsp_status,
   input  logic                                 csr_wr_en,
   input  logic [parst_pkg::LEN_W-1:0]          csr_wr_data
);
   import parst_pkg::*;

   cmd_type cmd;
   sts_type sts;

   parst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_wr_en (csr_wr_en),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   parst_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_func        (req_func),
      .req_position    (req_position),
      .req_right_end   (req_right_end),
      .req_delta       (req_delta),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_range_total (rsp_range_total),
      .rsp_status      (rsp_status)
   );

endmodule

// ===== test/point_add_range_sum_tree_top_test.sv =====
// Self-checking testbench for point_add_range_sum_tree_top: adds and range sums against a flat array.
module point_add_range_sum_tree_top_test;
   import parst_pkg::*;

   typedef struct {
      logic signed [VALUE_W-1:0] total;
      logic                      status;
   } sum_beat_type;

   // Holds a flat copy of the array; a range sum over it equals the tree's wrapped sum.
   class range_sum_scoreboard;
      logic [VALUE_W-1:0] pos_value [1:MAX_LEN];
      int unsigned        span;
      sum_beat_type       owed [$];
      int unsigned        errors;

      function new();
         errors = 0;
         resize(LEN_W'(MAX_LEN));
      endfunction

      // A length write clears the store; out-of-range lengths clamp to 1..MAX_LEN.
      function void resize(logic [LEN_W-1:0] length);
         span = (length == 0) ? 1 : ((length > MAX_LEN) ? MAX_LEN : length);
         foreach (pos_value[p]) pos_value[p] = '0;
      endfunction

      function void note_request(logic func, logic [LEN_W-1:0] left,
                                 logic [LEN_W-1:0] right, logic signed [VALUE_W-1:0] delta);
         sum_beat_type beat;
         int unsigned  lo;
         int unsigned  hi;
         beat.total  = '0;
         beat.status = STATUS_DONE;
         if (func == FUNC_ADD) begin
            if (left >= 1 && left <= span) pos_value[left] += delta;
            else beat.status = STATUS_IGNORED;
         end else begin
            // clip the range to 1..span; an empty range sums to zero
            lo = (left == 0) ? 1 : left;
            hi = (right > span) ? span : right;
            for (int unsigned p = lo; p <= hi; p++) beat.total += pos_value[p];
         end
         owed.push_back(beat);
      endfunction

      function void check_result(logic signed [VALUE_W-1:0] total, logic status);
         sum_beat_type want;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result beat: total %h status %b", total, status);
            return;
         end
         want = owed.pop_front();
         if (total !== want.total || status !== want.status) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: total %h (exp %h) status %b (exp %b)",
                        total, want.total, status, want.status);
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_func;
   logic [LEN_W-1:0]          req_position;
   logic [LEN_W-1:0]          req_right_end;
   logic signed [VALUE_W-1:0] req_delta;
   logic                      rsp_valid;
   logic signed [VALUE_W-1:0] rsp_range_total;
   logic                      rsp_status;
   logic                      csr_wr_en;
   logic [LEN_W-1:0]          csr_wr_data;

   range_sum_scoreboard sb;
   bit                  steady;

   point_add_range_sum_tree_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_position    (req_position),
      .req_right_end   (req_right_end),
      .req_delta       (req_delta),
      .rsp_valid       (rsp_valid),
      .rsp_range_total (rsp_range_total),
      .rsp_status      (rsp_status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_range_total, rsp_status);
   end

   initial begin
      #4000000;
      $display("TEST FAILED");
      $finish;
   end

   // Hold start until the block takes the beat; leave it high for a back-to-back item.
   task automatic send(logic func, logic [LEN_W-1:0] left, logic [LEN_W-1:0] right,
                       logic signed [VALUE_W-1:0] delta);
      int unsigned gap;
      gap = 0;
      if (!steady && $urandom_range(99) < 30) gap = $urandom_range(40, 1);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_func      <= func;
      req_position  <= left;
      req_right_end <= right;
      req_delta     <= delta;
      do @(posedge clock); while (busy);
      sb.note_request(func, left, right, delta);
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (busy || sb.owed.size() != 0);
   endtask

   task automatic write_length(logic [LEN_W-1:0] length);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= length;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.resize(length);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_delta();
      case ($urandom_range(9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly in-range adds and queries; the rest is noise over the full field widths.
   task automatic random_item();
      int unsigned      pick;
      logic [LEN_W-1:0] left;
      logic [LEN_W-1:0] right;
      pick = $urandom_range(99);
      left = LEN_W'($urandom_range(sb.span, 1));
      if (pick < 55) begin
         send(FUNC_ADD, left, LEN_W'($urandom), pick_delta());
      end else if (pick < 62) begin
         send(FUNC_QUERY, LEN_W'(1), LEN_W'(sb.span), $urandom);
      end else if (pick < 90) begin
         right = LEN_W'($urandom_range(sb.span, left));
         send(FUNC_QUERY, left, right, $urandom);
      end else begin
         send(1'($urandom), LEN_W'($urandom), LEN_W'($urandom), $urandom);
      end
   endtask

   initial begin
      int unsigned lengths [7];
      lengths       = '{1, 2, 0, 2047, 7, 0, 1024};
      sb            = new();
      steady        = 1'b0;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_func      <= FUNC_ADD;
      req_position  <= '0;
      req_right_end <= '0;
      req_delta     <= '0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      lengths[5]    = $urandom_range(1023, 3);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // edges of the array, extreme amounts, ignored adds, clipped and empty queries
      send(FUNC_ADD,   11'd1,    11'd0,    32'sh7FFF_FFFF);
      send(FUNC_ADD,   11'd1024, 11'd2047, 32'sh8000_0000);
      send(FUNC_ADD,   11'd512,  11'd5,    32'sd1);
      send(FUNC_ADD,   11'd513,  11'd5,    -32'sd1);
      send(FUNC_ADD,   11'd0,    11'd1,    32'sd99);
      send(FUNC_ADD,   11'd1025, 11'd1,    32'sd99);
      send(FUNC_ADD,   11'd2047, 11'd2047, -32'sd1);
      send(FUNC_QUERY, 11'd1,    11'd1024, 32'sd0);
      send(FUNC_QUERY, 11'd1,    11'd1,    -32'sd1);
      send(FUNC_QUERY, 11'd1024, 11'd1024, 32'sd0);
      send(FUNC_QUERY, 11'd0,    11'd2047, 32'sd0);
      send(FUNC_QUERY, 11'd5,    11'd4,    32'sd0);
      send(FUNC_QUERY, 11'd1025, 11'd2047, 32'sd0);
      send(FUNC_QUERY, 11'd0,    11'd0,    32'sd0);
      send(FUNC_QUERY, 11'd512,  11'd513,  32'sd0);
      send(FUNC_ADD,   11'd1,    11'd0,    32'sd1);
      send(FUNC_QUERY, 11'd1,    11'd1,    32'sd0);
      send(FUNC_QUERY, 11'd2,    11'd1023, 32'sd0);
      send(FUNC_QUERY, 11'd2047, 11'd1,    32'sd0);
      send(FUNC_ADD,   11'd700,  11'd0,    32'sh5A5A_A5A5);
      send(FUNC_QUERY, 11'd600,  11'd800,  32'sd0);

      repeat (60) random_item();
      foreach (lengths[i]) begin
         write_length(LEN_W'(lengths[i]));
         // one phase runs back to back with no gaps on the request side
         steady = (i == 2);
         repeat (50) random_item();
      end
      steady = 1'b0;

      settle();
      repeat (100) @(posedge clock);
      if (sb.owed.size() != 0) sb.errors++;
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/parst_pkg.sv
rtl/core/parst_datapath.sv
rtl/core/parst_ctrl.sv
rtl/core/point_add_range_sum_tree_top.sv
test/point_add_range_sum_tree_top_test.sv
